@@ hw/rtl/cbat_pkg.sv @@
// Shared types and constants of the CAN arbitration timer.
`default_nettype none
package cbat_pkg;
	localparam int TIME_W  = 56;
	localparam int ID_W    = 11;
	localparam int BITS_W  = 8;
	localparam int SEQ_W   = 32;
	localparam int BAUD_W  = 20;
	localparam int PSC_W   = 40;
	localparam int DIV_W   = 48;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_TAG_BITS    = 16;

	localparam logic [BAUD_W-1:0] BAUD_RESET = BAUD_W'(500000);
	localparam logic [PSC_W-1:0]  PS_PER_SEC = PSC_W'(64'd1000000000000);
	localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_DONE     = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENQ_OUT,
		S_CHECK,
		S_RETIRE,
		S_SCAN_EARLY,
		S_SCAN_WIN,
		S_MUL,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [BITS_W-1:0] bits;
		logic [TIME_W-1:0] ready;
		logic [SEQ_W-1:0]  seq;
	} slot_t;

	typedef struct packed {
		logic in_ready;
		logic scan;
		logic div_start;
	} ctrl_t;
endpackage
`default_nettype wire

@@ hw/rtl/cbat_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module cbat_div import cbat_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_W-1:0]  dividend,
	input  wire logic [BAUD_W-1:0] divisor,
	output logic                   done,
	output logic [DIV_W-1:0]       quotient
);
	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]  quo_q;
	logic [BAUD_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [BAUD_W:0]   trial;
	logic [BAUD_W:0]   rem_n;
	logic              ge;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		ge    = trial >= {1'b0, divisor};
		rem_n = ge ? trial - {1'b0, divisor} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rem_n[BAUD_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

@@ hw/rtl/can_bus_arbitration_timer_top.sv @@
// CAN arbitration timer: pending frame table, arbitration sequencer, result register.
//
// Input channel (in_valid/in_ready) takes one transaction at a time: mode 0
// enqueues a frame, mode 1 advances bus time to time_ps and retires frames.
// Output channel (out_valid/out_ready) returns results from one output
// register; last marks the final result of a transaction. An enqueue gives
// one result, an advance gives one per retired frame or a single idle result.
// in_ready is high only while the sequencer is idle; a result may still wait.
// An enqueue passes through S_ENQ_OUT to its result. An advance runs, per started
// frame, a check, two table scans (one memory read port), a multiply, a divider
// start and the bit-serial divider; each retirement passes through S_RETIRE and
// may wait on an output stall. A stalled receiver freezes the sequencer at the
// next result. Reset empties the table, clears the bus state and sets the bit
// rate to 500000. The user writes the bit rate through cfg_we/cfg_wdata only
// while idle; the block itself does not enforce this. 0 acts as 1.
`default_nettype none
module can_bus_arbitration_timer_top import cbat_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int TAG_BITS    = DEF_TAG_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [BAUD_W-1:0]   cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                mode,
	input  wire logic [TAG_BITS-1:0] frame_tag,
	input  wire logic [ID_W-1:0]     can_id,
	input  wire logic [BITS_W-1:0]   frame_bits,
	input  wire logic [TIME_W-1:0]   time_ps,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               status,
	output logic [TAG_BITS-1:0]      done_tag,
	output logic [ID_W-1:0]          done_can_id,
	output logic [TIME_W-1:0]        arb_start_ps,
	output logic [TIME_W-1:0]        finish_ps,
	output logic                     last
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_n;
	ctrl_t  ctrl;

	logic [BAUD_W-1:0] baud_q;
	logic [BAUD_W-1:0] baud_eff;

	// pending table
	slot_t               mem [QUEUE_DEPTH];
	logic [TAG_BITS-1:0] tag_mem [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [SEQ_W-1:0]    seq_q;

	// latched limit
	logic [TIME_W-1:0] limit_q;
	status_t           enq_status_q;

	// active frame and bus time
	logic                busy_valid_q;
	logic [TAG_BITS-1:0] busy_tag_q;
	logic [ID_W-1:0]     busy_id_q;
	logic [TIME_W-1:0]   busy_start_q;
	logic [TIME_W-1:0]   busy_finish_q;
	logic [TIME_W-1:0]   bus_free_q;

	// retired frame held back until we know whether it is the final one
	logic                pend_valid_q;
	logic [TAG_BITS-1:0] pend_tag_q;
	logic [ID_W-1:0]     pend_id_q;
	logic [TIME_W-1:0]   pend_start_q;
	logic [TIME_W-1:0]   pend_finish_q;

	// scan
	logic [CW-1:0]       cnt_q;
	logic                ph_s1;
	logic                rv_s1;
	slot_t               rd_s1;
	logic [TAG_BITS-1:0] rtag_s1;
	logic [AW-1:0]       ridx_s1;
	logic                any_q;
	logic [TIME_W-1:0]   early_q;
	logic [TIME_W-1:0]   start_q;
	logic                win_any_q;
	logic [AW-1:0]       win_idx_q;
	slot_t               win_q;
	logic [TAG_BITS-1:0] win_tag_q;
	logic [DIV_W-1:0]    dividend_q;

	// result register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [TAG_BITS-1:0] out_tag_q;
	logic [ID_W-1:0]     out_id_q;
	logic [TIME_W-1:0]   out_start_q;
	logic [TIME_W-1:0]   out_finish_q;
	logic                out_last_q;

	logic                out_free;
	logic                out_load;
	logic                scan_end;
	logic [AW-1:0]       rd_addr;
	logic                free_found;
	logic [AW-1:0]       free_idx;
	logic                div_done;
	logic [DIV_W-1:0]    dur;
	logic [TIME_W:0]     fin_sum;
	logic [TIME_W-1:0]   fin;
	logic [TIME_W-1:0]   start_calc;
	logic                early_take;
	logic [TIME_W-1:0]   early_nx;
	logic                win_take;
	logic                better;
	logic                in_acc;

	assign baud_eff = (baud_q == '0) ? BAUD_W'(1) : baud_q;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && ((state_q == S_ENQ_OUT) || (state_q == S_FINISH) ||
		((state_q == S_RETIRE) && pend_valid_q));
	assign scan_end = (cnt_q == CW'(QUEUE_DEPTH));
	assign rd_addr  = cnt_q[AW-1:0];
	assign in_acc   = in_valid && ctrl.in_ready;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	always_comb begin
		// the last slot of a scan arrives in the scan_end cycle
		early_take = ph_s1 && rv_s1 && (!any_q || rd_s1.ready < early_q);
		early_nx   = early_take ? rd_s1.ready : early_q;
		start_calc = (bus_free_q > early_nx) ? bus_free_q : early_nx;
		better = !win_any_q || (rd_s1.id < win_q.id) ||
			((rd_s1.id == win_q.id) && (rd_s1.seq < win_q.seq));
		win_take = ph_s1 && rv_s1 && (rd_s1.ready <= start_q) && better;
		fin_sum = {1'b0, busy_start_q} + {{(TIME_W + 1 - DIV_W){1'b0}}, dur};
		fin     = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:       if (in_valid) state_n = mode ? S_CHECK : S_ENQ_OUT;
			S_ENQ_OUT:    if (out_free) state_n = S_IDLE;
			S_CHECK: begin
				if (busy_valid_q) state_n = (busy_finish_q > limit_q) ? S_FINISH : S_RETIRE;
				else state_n = S_SCAN_EARLY;
			end
			S_RETIRE:     if (!pend_valid_q || out_free) state_n = S_CHECK;
			S_SCAN_EARLY: if (scan_end) state_n = (any_q || (ph_s1 && rv_s1)) ? S_SCAN_WIN
				: S_FINISH;
			S_SCAN_WIN:   if (scan_end) state_n = S_MUL;
			S_MUL:        state_n = S_DIV_GO;
			S_DIV_GO:     state_n = S_DIV_WAIT;
			S_DIV_WAIT:   if (div_done) state_n = S_CHECK;
			S_FINISH:     if (out_free) state_n = S_IDLE;
			default:      state_n = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			S_IDLE:       ctrl.in_ready  = 1'b1;
			S_SCAN_EARLY: ctrl.scan      = 1'b1;
			S_SCAN_WIN:   ctrl.scan      = 1'b1;
			S_DIV_GO:     ctrl.div_start = 1'b1;
			default:      ctrl = '0;
		endcase
	end

	cbat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend (dividend_q),
		.divisor  (baud_eff),
		.done     (div_done),
		.quotient (dur)
	);

	// table storage, one write and one registered read
	always_ff @(posedge clk) begin
		if (in_acc && !mode && free_found) begin
			mem[free_idx]     <= '{id: can_id, bits: frame_bits, ready: time_ps, seq: seq_q};
			tag_mem[free_idx] <= frame_tag;
		end
		rd_s1   <= mem[rd_addr];
		rtag_s1 <= tag_mem[rd_addr];
		ridx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			baud_q       <= BAUD_RESET;
			valid_q      <= '0;
			seq_q        <= '0;
			busy_valid_q <= 1'b0;
			busy_tag_q   <= '0;
			busy_id_q    <= '0;
			busy_start_q <= '0;
			busy_finish_q <= '0;
			bus_free_q   <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
			ph_s1        <= 1'b0;
			rv_s1        <= 1'b0;
			any_q        <= 1'b0;
			win_any_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) baud_q <= cfg_wdata;
			out_valid_q <= out_load || (out_valid_q && !out_ready);

			ph_s1 <= ctrl.scan && !scan_end;
			rv_s1 <= ctrl.scan && !scan_end && valid_q[rd_addr];
			if (ctrl.scan) cnt_q <= scan_end ? '0 : cnt_q + 1'b1;
			else cnt_q <= '0;

			unique case (state_q)
				S_IDLE: begin
					any_q     <= 1'b0;
					win_any_q <= 1'b0;
					if (in_acc && !mode && free_found) begin
						valid_q[free_idx] <= 1'b1;
						seq_q             <= seq_q + 1'b1;
					end
				end
				S_CHECK: begin
					any_q     <= 1'b0;
					win_any_q <= 1'b0;
				end
				S_RETIRE: begin
					if (!pend_valid_q || out_free) begin
						pend_valid_q <= 1'b1;
						busy_valid_q <= 1'b0;
					end
				end
				S_SCAN_EARLY: begin
					if (early_take) any_q <= 1'b1;
				end
				S_SCAN_WIN: begin
					if (win_take) win_any_q <= 1'b1;
					if (scan_end) valid_q[win_take ? ridx_s1 : win_idx_q] <= 1'b0;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						busy_valid_q  <= 1'b1;
						busy_tag_q    <= win_tag_q;
						busy_id_q     <= win_q.id;
						busy_finish_q <= fin;
						bus_free_q    <= fin;
					end
				end
				S_FINISH: begin
					if (out_free) pend_valid_q <= 1'b0;
				end
				default: ;
			endcase
			if (state_q == S_MUL) busy_start_q <= start_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			limit_q      <= time_ps;
			enq_status_q <= free_found ? ST_ACCEPTED : ST_FULL;
		end
		if (state_q == S_SCAN_EARLY && early_take)
			early_q <= rd_s1.ready;
		if (state_q == S_SCAN_EARLY && scan_end) start_q <= start_calc;
		if (state_q == S_SCAN_WIN && win_take) begin
			win_q     <= rd_s1;
			win_tag_q <= rtag_s1;
			win_idx_q <= ridx_s1;
		end
		if (state_q == S_MUL)
			dividend_q <= DIV_W'(win_q.bits) * DIV_W'(PS_PER_SEC) + DIV_W'(baud_eff)
				- DIV_W'(1);

		if (state_q == S_ENQ_OUT && out_free) begin
			out_status_q <= enq_status_q;
			out_tag_q    <= '0;
			out_id_q     <= '0;
			out_start_q  <= '0;
			out_finish_q <= '0;
			out_last_q   <= 1'b1;
		end
		if (state_q == S_RETIRE && (!pend_valid_q || out_free)) begin
			if (pend_valid_q) begin
				out_status_q <= ST_DONE;
				out_tag_q    <= pend_tag_q;
				out_id_q     <= pend_id_q;
				out_start_q  <= pend_start_q;
				out_finish_q <= pend_finish_q;
				out_last_q   <= 1'b0;
			end
			pend_tag_q    <= busy_tag_q;
			pend_id_q     <= busy_id_q;
			pend_start_q  <= busy_start_q;
			pend_finish_q <= busy_finish_q;
		end
		if (state_q == S_FINISH && out_free) begin
			out_status_q <= pend_valid_q ? ST_DONE : ST_NONE;
			out_tag_q    <= pend_valid_q ? pend_tag_q : '0;
			out_id_q     <= pend_valid_q ? pend_id_q : '0;
			out_start_q  <= pend_valid_q ? pend_start_q : '0;
			out_finish_q <= pend_valid_q ? pend_finish_q : '0;
			out_last_q   <= 1'b1;
		end
	end

	assign in_ready     = ctrl.in_ready;
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign done_tag     = out_tag_q;
	assign done_can_id  = out_id_q;
	assign arb_start_ps = out_start_q;
	assign finish_ps    = out_finish_q;
	assign last         = out_last_q;
endmodule
`default_nettype wire
